// ===== src/magnetometer_calibrate_heading_assert.svh =====
// Assertion macros shared by the magnetometer calibration RTL.
// Each macro checks a property on the rising edge of i_clk, held off in reset.
`ifndef MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH
`define MAGNETOMETER_CALIBRATE_HEADING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MCH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mch_pkg.sv =====
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types, codes, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mch_pkg;

    localparam int CORDIC_STEPS_DEF        = 16;
    localparam int SCALE_FRACTION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF         = 2;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_MEASURE = 2'd0;
    localparam logic [1:0] CMD_CAL     = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic signed [15:0] MIN_RESET  = 16'sh7FFF;
    localparam logic signed [15:0] MAX_RESET  = 16'sh8000;
    localparam logic signed [15:0] DECL_RESET = 16'sd137;

    localparam int CAL_LIMIT     = 32767;
    localparam int HEADING_FULL  = 36000;
    localparam int ANGLE_QUARTER = 2304000;   // 9000 centidegrees in Q.8
    localparam int ATAN_W        = 21;

    typedef enum logic [1:0] {
        OP_MEASURE,
        OP_CAL,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXTREME,
        S_CAL_CHECK,
        S_DIV,
        S_OFF_MUL,
        S_OFF_ADD,
        S_MUL,
        S_ACC,
        S_CINIT,
        S_CITER,
        S_HEAD,
        S_WRITE
    } t_state;

    // atan(2^-i) in centidegrees, Q.8.
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 21'd1152000;
            5'd1:    v = 21'd680065;
            5'd2:    v = 21'd359328;
            5'd3:    v = 21'd182400;
            5'd4:    v = 21'd91554;
            5'd5:    v = 21'd45822;
            5'd6:    v = 21'd22916;
            5'd7:    v = 21'd11459;
            5'd8:    v = 21'd5730;
            5'd9:    v = 21'd2865;
            5'd10:   v = 21'd1432;
            5'd11:   v = 21'd716;
            5'd12:   v = 21'd358;
            5'd13:   v = 21'd179;
            5'd14:   v = 21'd90;
            5'd15:   v = 21'd45;
            5'd16:   v = 21'd22;
            5'd17:   v = 21'd11;
            5'd18:   v = 21'd6;
            5'd19:   v = 21'd3;
            5'd20:   v = 21'd1;
            5'd21:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== src/mch_front.sv =====
// ----------------------------------------------------------------------------
// mch_front
// Joins the sensor bytes into signed axes and classifies the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mch_front
    import mch_pkg::*;
(
    input  wire logic       i_push,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_x_high,
    input  wire logic [7:0] i_x_low,
    input  wire logic [7:0] i_z_high,
    input  wire logic [7:0] i_z_low,
    input  wire logic [7:0] i_y_high,
    input  wire logic [7:0] i_y_low,
    input  wire logic       i_q_full,
    output logic            o_full,
    output logic            o_q_push,
    output t_item           o_q_item
);

    // Decode the command; the unused code behaves as a measurement.
    // Sensor order is X, Z, Y; bytes join high:low.
    always_comb begin
        unique case (i_command)
            CMD_CAL:   o_q_item.op = OP_CAL;
            CMD_CLEAR: o_q_item.op = OP_CLEAR;
            default:   o_q_item.op = OP_MEASURE;
        endcase
        o_q_item.raw_x = signed'({i_x_high, i_x_low});
        o_q_item.raw_y = signed'({i_y_high, i_y_low});
        o_q_item.raw_z = signed'({i_z_high, i_z_low});
    end

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

`default_nettype wire

// ===== src/mch_queue.sv =====
// ----------------------------------------------------------------------------
// mch_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mch_queue
    import mch_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_item     o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Storage for each transfer in.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`include "magnetometer_calibrate_heading_assert.svh"
    `MCH_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `MCH_ASSERT_NOW(a_no_pop_empty, i_pop, r_count != '0)
    `MCH_ASSERT_NOW(a_no_push_full, i_push, !o_full || i_pop)

endmodule

`default_nettype wire

// ===== src/mch_back.sv =====
// ----------------------------------------------------------------------------
// mch_back
// Sequencer: calibration update with a serial divider, calibrated axes on a
// shared multiplier, CORDIC heading and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mch_back
    import mch_pkg::*;
#(
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
    parameter int SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [15:0] i_cfg_wdata,
    input  wire logic               i_q_empty,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output logic signed      [15:0] o_cal_x,
    output logic signed      [15:0] o_cal_y,
    output logic signed      [15:0] o_cal_z,
    output logic             [15:0] o_heading,
    output logic                    o_status
);

    localparam int F   = SCALE_FRACTION_BITS;
    localparam int QW  = 11 + F;              // scale width
    localparam int DW  = QW + 1;              // dividend width
    localparam int DCW = $clog2(DW + 1);
    localparam int PW  = 17 + QW;             // product width
    localparam int FW  = PW + 2;              // offset and accumulate width
    localparam int OW  = 26;                  // offset width
    localparam int CRW = 27;                  // CORDIC vector width
    localparam int ZW  = 25;                  // CORDIC angle width
    localparam int HW  = 27;                  // heading sum width
    localparam int IW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    localparam logic [FW-1:0] OFF_HALF =
        (F > 8) ? (FW'(1) << ((F > 8) ? F - 9 : 0)) : '0;
    localparam logic [FW-1:0] ACC_HALF  = FW'(1) << (F - 1);
    localparam logic [FW-1:0] THOUSAND  = FW'(1000) << F;
    localparam logic [DW-1:0] NUMERATOR = DW'(2000) << F;

    t_state r_state, n_state;

    // Item under work.
    t_op                r_op;
    logic signed [15:0] r_raw [3];
    logic        [1:0]  r_axis;
    logic               r_status;

    // Calibration state per axis.
    logic signed [15:0]   r_min   [3];
    logic signed [15:0]   r_max   [3];
    logic        [QW-1:0] r_scale [3];
    logic signed [OW-1:0] r_off   [3];
    logic signed [15:0]   r_decl;

    // Divider, multiplier and results.
    logic        [DW-1:0]  r_dvd;
    logic        [16:0]    r_rem;
    logic        [15:0]    r_span;
    logic        [DCW-1:0] r_dcnt;
    logic signed [PW-1:0]  r_prod;
    logic signed [15:0]    r_cal [3];

    // CORDIC.
    logic signed [CRW-1:0] r_re, r_im;
    logic signed [ZW-1:0]  r_z;
    logic        [IW-1:0]  r_iter;
    logic        [15:0]    r_head;

    // Output register.
    logic               r_out_valid;
    logic signed [15:0] r_out_x, r_out_y, r_out_z;
    logic        [15:0] r_out_head;
    logic               r_out_status;

    logic last_axis;
    logic out_free;
    assign last_axis = (r_axis == 2'd2);
    assign out_free  = !r_out_valid || i_pop;

    // Next state and queue pop.
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = S_EXTREME;
                end
            end
            S_EXTREME:   n_state = (r_op == OP_CAL) ? S_CAL_CHECK : S_MUL;
            S_CAL_CHECK: begin
                if (r_max[r_axis] > r_min[r_axis]) begin
                    n_state = S_DIV;
                end else if (last_axis) begin
                    n_state = S_MUL;
                end
            end
            S_DIV:       n_state = (r_dcnt == DCW'(1)) ? S_OFF_MUL : S_DIV;
            S_OFF_MUL:   n_state = S_OFF_ADD;
            S_OFF_ADD:   n_state = last_axis ? S_MUL : S_CAL_CHECK;
            S_MUL:       n_state = S_ACC;
            S_ACC:       n_state = last_axis ? S_CINIT : S_MUL;
            S_CINIT: begin
                n_state = (r_cal[0] == '0 && r_cal[1] == '0) ? S_HEAD : S_CITER;
            end
            S_CITER:     n_state = (r_iter == IW'(CORDIC_STEPS - 1)) ? S_HEAD : S_CITER;
            S_HEAD:      n_state = S_WRITE;
            S_WRITE:     n_state = out_free ? S_IDLE : S_WRITE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Span of the current axis as an unsigned count.
    logic [15:0] span_now;
    assign span_now = 16'(r_max[r_axis] - r_min[r_axis]);

    // Divider step: one quotient bit per cycle.
    logic [16:0] div_trial;
    logic        div_bit;
    assign div_trial = {r_rem[15:0], r_dvd[DW-1]};
    assign div_bit   = (div_trial >= {1'b0, r_span});

    // Shared multiplier: signed axis value times unsigned scale.
    logic signed [15:0]   mul_a;
    logic        [QW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    assign mul_a = (r_state == S_OFF_MUL) ? r_max[r_axis] : r_raw[r_axis];
    assign mul_b = (r_state == S_OFF_MUL) ? r_dvd[QW-1:0] : r_scale[r_axis];
    assign mul_p = PW'(mul_a) * PW'(signed'({1'b0, mul_b}));

    // Offset: 1000 - max*scale, rounded to Q.8 and saturated.
    logic signed [FW-1:0] off_full, off_shift;
    logic signed [OW-1:0] off_sat;
    assign off_full  = signed'(THOUSAND) - FW'(r_prod) + signed'(OFF_HALF);
    assign off_shift = off_full >>> (F - 8);
    always_comb begin
        if (off_shift > FW'(33554431)) begin
            off_sat = OW'(33554431);
        end else if (off_shift < -FW'(33554432)) begin
            off_sat = OW'(-33554432);
        end else begin
            off_sat = off_shift[OW-1:0];
        end
    end

    // Calibrated value: scale*raw + offset, rounded and saturated.
    logic signed [FW-1:0] acc_sum, acc_shift;
    logic signed [15:0]   acc_sat;
    assign acc_sum   = FW'(r_prod) + (FW'(r_off[r_axis]) <<< (F - 8)) + signed'(ACC_HALF);
    assign acc_shift = acc_sum >>> F;
    always_comb begin
        if (acc_shift > FW'(CAL_LIMIT)) begin
            acc_sat = 16'(CAL_LIMIT);
        end else if (acc_shift < -FW'(CAL_LIMIT)) begin
            acc_sat = -16'(CAL_LIMIT);
        end else begin
            acc_sat = acc_shift[15:0];
        end
    end

    // CORDIC iteration terms.
    logic signed [CRW-1:0] cor_dr, cor_di;
    logic signed [ZW-1:0]  cor_at;
    assign cor_dr = r_im >>> r_iter;
    assign cor_di = r_re >>> r_iter;
    assign cor_at = ZW'(atan_lut(5'(r_iter)));

    // Heading: add declination, round, wrap once, clamp.
    logic signed [HW-1:0] head_sum;
    logic signed [HW-9:0] head_r, head_w1, head_w2;
    assign head_sum = HW'(r_z) + (HW'(r_decl) <<< 8) + HW'(128);
    assign head_r   = head_sum[HW-1:8];
    assign head_w1  = (head_r < 0) ? head_r + (HW-8)'(HEADING_FULL) : head_r;
    assign head_w2  = (head_w1 > (HW-8)'(HEADING_FULL)) ? head_w1 - (HW-8)'(HEADING_FULL)
                                                          : head_w1;

    // Calibration state and declination register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_min[k]   <= MIN_RESET;
                r_max[k]   <= MAX_RESET;
                r_scale[k] <= QW'(1) << F;
                r_off[k]   <= '0;
            end
            r_decl <= DECL_RESET;
        end else begin
            if (i_cfg_we) begin
                r_decl <= signed'(i_cfg_wdata);
            end
            if (r_state == S_EXTREME) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_op == OP_CLEAR) begin
                        r_min[k] <= MIN_RESET;
                        r_max[k] <= MAX_RESET;
                    end else if (r_op == OP_CAL) begin
                        if (r_raw[k] < r_min[k]) r_min[k] <= r_raw[k];
                        if (r_raw[k] > r_max[k]) r_max[k] <= r_raw[k];
                    end
                end
            end
            if (r_state == S_OFF_MUL) begin
                r_scale[r_axis] <= r_dvd[QW-1:0];
            end
            if (r_state == S_OFF_ADD) begin
                r_off[r_axis] <= off_sat;
            end
        end
    end

    // Datapath registers of the item under work.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op     <= i_q_item.op;
                r_raw[0] <= i_q_item.raw_x;
                r_raw[1] <= i_q_item.raw_y;
                r_raw[2] <= i_q_item.raw_z;
                r_axis   <= 2'd0;
                r_status <= 1'b0;
            end
            S_EXTREME: r_axis <= 2'd0;
            S_CAL_CHECK: begin
                r_span <= span_now;
                r_rem  <= '0;
                r_dcnt <= DCW'(DW);
                r_dvd  <= NUMERATOR + DW'(span_now >> 1);
                if (!(r_max[r_axis] > r_min[r_axis])) begin
                    r_status <= 1'b1;
                    r_axis   <= last_axis ? 2'd0 : r_axis + 2'd1;
                end
            end
            S_DIV: begin
                r_rem  <= div_bit ? div_trial - {1'b0, r_span} : div_trial;
                r_dvd  <= {r_dvd[DW-2:0], div_bit};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_OFF_MUL: r_prod <= mul_p;
            S_OFF_ADD: r_axis <= last_axis ? 2'd0 : r_axis + 2'd1;
            S_MUL:     r_prod <= mul_p;
            S_ACC: begin
                r_cal[r_axis] <= acc_sat;
                r_axis        <= last_axis ? 2'd0 : r_axis + 2'd1;
            end
            S_CINIT: begin
                r_iter <= '0;
                if (r_cal[0] == '0 && r_cal[1] == '0) begin
                    r_z  <= '0;
                    r_re <= '0;
                    r_im <= '0;
                end else if (r_cal[1] >= 0) begin
                    r_re <= CRW'(r_cal[1]) <<< 8;
                    r_im <= CRW'(r_cal[0]) <<< 8;
                    r_z  <= '0;
                end else if (r_cal[0] >= 0) begin
                    r_re <= CRW'(r_cal[0]) <<< 8;
                    r_im <= -(CRW'(r_cal[1]) <<< 8);
                    r_z  <= ZW'(ANGLE_QUARTER);
                end else begin
                    r_re <= -(CRW'(r_cal[0]) <<< 8);
                    r_im <= CRW'(r_cal[1]) <<< 8;
                    r_z  <= -ZW'(ANGLE_QUARTER);
                end
            end
            S_CITER: begin
                r_iter <= r_iter + 1'b1;
                if (r_im >= 0) begin
                    r_re <= r_re + cor_dr;
                    r_im <= r_im - cor_di;
                    r_z  <= r_z + cor_at;
                end else begin
                    r_re <= r_re - cor_dr;
                    r_im <= r_im + cor_di;
                    r_z  <= r_z - cor_at;
                end
            end
            S_HEAD: begin
                if (head_w2 < 0) begin
                    r_head <= '0;
                end else if (head_w2 > (HW-8)'(HEADING_FULL)) begin
                    r_head <= 16'(HEADING_FULL);
                end else begin
                    r_head <= head_w2[15:0];
                end
            end
            default: ;
        endcase
    end

    // Output register: filled when free, emptied by a result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_WRITE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && out_free) begin
            r_out_x      <= r_cal[0];
            r_out_y      <= r_cal[1];
            r_out_z      <= r_cal[2];
            r_out_head   <= r_head;
            r_out_status <= r_status;
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_cal_x   = r_out_x;
    assign o_cal_y   = r_out_y;
    assign o_cal_z   = r_out_z;
    assign o_heading = r_out_head;
    assign o_status  = r_out_status;

`include "magnetometer_calibrate_heading_assert.svh"
    `MCH_ASSERT_NEXT(a_write_fills, r_state == S_WRITE && out_free, r_out_valid)
    `MCH_ASSERT_NOW(a_heading_range, r_out_valid, r_out_head <= 16'(HEADING_FULL))
    `MCH_ASSERT_NOW(a_cal_sat, r_out_valid, r_out_x != 16'sh8000 && r_out_y != 16'sh8000)
    `MCH_ASSERT_NOW(a_axis_range, 1'b1, r_axis != 2'd3)

endmodule

`default_nettype wire

// ===== src/magnetometer_calibrate_heading.sv =====
// ----------------------------------------------------------------------------
// magnetometer_calibrate_heading
// Min/max magnetometer calibration with a CORDIC compass heading.
// ----------------------------------------------------------------------------
// Channel   Handshake          Payload
// input     push / full        command, x/z/y high and low bytes
// result    empty / pop        cal_x, cal_y, cal_z, heading, status
// config    i_cfg_we           i_cfg_wdata (declination)
//
// A measure or clear item runs extreme update, multiply and accumulate per
// axis, CORDIC setup, CORDIC iterations (skipped when cal_x and cal_y are
// both zero), heading and write; a calibration item adds, per axis with max
// above min, a serial divider (one quotient bit per cycle) and offset update.
// The back sequencer handles one item at a time; a two-entry queue takes new
// items meanwhile, and a full output register stalls only the final write.
// Synchronous active-low reset restores the calibration and declination.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_calibrate_heading
    import mch_pkg::*;
#(
    parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
    parameter int SCALE_FRACTION_BITS = SCALE_FRACTION_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [15:0] i_cfg_wdata,
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [1:0]  i_command,
    input  wire logic        [7:0]  i_x_high,
    input  wire logic        [7:0]  i_x_low,
    input  wire logic        [7:0]  i_z_high,
    input  wire logic        [7:0]  i_z_low,
    input  wire logic        [7:0]  i_y_high,
    input  wire logic        [7:0]  i_y_low,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed      [15:0] o_cal_x,
    output logic signed      [15:0] o_cal_y,
    output logic signed      [15:0] o_cal_z,
    output logic             [15:0] o_heading,
    output logic                    o_status
);

    t_item q_in_item, q_out_item;
    logic  q_push, q_pop, q_full, q_empty;

    // Front: byte join and command decode.
    mch_front u_front (
        .i_push    (push),
        .i_command (i_command),
        .i_x_high  (i_x_high),
        .i_x_low   (i_x_low),
        .i_z_high  (i_z_high),
        .i_z_low   (i_z_low),
        .i_y_high  (i_y_high),
        .i_y_low   (i_y_low),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_push  (q_push),
        .o_q_item  (q_in_item)
    );

    // Queue between front and back.
    mch_queue #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    // Back: calibration, calibrated axes, heading, result register.
    mch_back #(
        .CORDIC_STEPS        (CORDIC_STEPS),
        .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_cal_x     (o_cal_x),
        .o_cal_y     (o_cal_y),
        .o_cal_z     (o_cal_z),
        .o_heading   (o_heading),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire
